// File: src/sdf_pkg.sv
// spring_damper_force package: field widths, register indexes and
// fixed-point helpers for the datapath; the checker and the testbench import it too.
// No dependencies.
package sdf_pkg;

   localparam int unsigned FieldW = 32;
   localparam int unsigned CoefW = 31;
   localparam int unsigned InFields = 12;
   localparam int unsigned OutFields = 7;
   localparam int unsigned ReqDataW = FieldW * InFields;
   localparam int unsigned RspDataW = FieldW * OutFields;
   localparam int unsigned CsrIdxW = 3;

   // sqrt of a 66-bit sum gives a 33-bit root
   localparam int unsigned SumW = 66;
   localparam int unsigned RootW = 33;
   // quotient of d*65536 by the length: |u| stays within 18 bits signed
   localparam int unsigned DivW = 48;
   localparam int unsigned DirW = 18;

   localparam logic [CoefW-1:0] KReset = 31'd65536;
   localparam logic [CoefW-1:0] CReset = 31'd0;
   localparam logic signed [FieldW-1:0] GxReset = 32'sd0;
   localparam logic signed [FieldW-1:0] GyReset = -32'sd642908;
   localparam logic signed [FieldW-1:0] GzReset = 32'sd0;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_STIFFNESS_K = 3'd0,
      CSR_DAMPING_C   = 3'd1,
      CSR_GRAVITY_X   = 3'd2,
      CSR_GRAVITY_Y   = 3'd3,
      CSR_GRAVITY_Z   = 3'd4
   } csr_index_type;

   // saturate a wide signed value to 32 bits
   function automatic logic signed [FieldW-1:0] sat32(input logic signed [127:0] v);
      logic signed [127:0] hi;
      logic signed [127:0] lo;
      hi = 128'sd2147483647;
      lo = -128'sd2147483648;
      if (v > hi) return 32'sh7fffffff;
      if (v < lo) return 32'sh80000000;
      return v[FieldW-1:0];
   endfunction

endpackage

// File: src/sdf_isqrt.sv
// spring_damper_force square root pipeline: one result bit per stage,
// restoring method over a 66-bit radicand. Depends on sdf_pkg.
module sdf_isqrt #(
   parameter int unsigned TagW = 8
) (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [sdf_pkg::SumW-1:0]    rad,
   input  logic [TagW-1:0]             tag_in,
   output logic [sdf_pkg::RootW-1:0]   root,
   output logic [TagW-1:0]             tag_out
);
   import sdf_pkg::*;

   localparam int unsigned Steps = RootW;
   localparam int unsigned RemW = RootW + 2;

   logic [SumW-1:0]  rad_ff  [Steps+1];
   logic [RemW-1:0]  rem_ff  [Steps+1];
   logic [RootW-1:0] root_ff [Steps+1];
   logic [TagW-1:0]  tag_ff  [Steps+1];

   always_comb begin
      rad_ff[0]  = rad;
      rem_ff[0]  = '0;
      root_ff[0] = '0;
      tag_ff[0]  = tag_in;
   end

   // one bit pair of the radicand per stage
   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [RemW-1:0]  rem_in;
      logic [RemW-1:0]  trial;
      logic [RootW-1:0] root_in;
      always_comb begin
         rem_in = {rem_ff[s][RemW-3:0], rad_ff[s][SumW-1 -: 2]};
         trial  = {root_ff[s], 2'b01};
         if (rem_in >= trial) begin
            rem_in  = rem_in - trial;
            root_in = {root_ff[s][RootW-2:0], 1'b1};
         end else begin
            root_in = {root_ff[s][RootW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[s+1]  <= {rad_ff[s][SumW-3:0], 2'b00};
            rem_ff[s+1]  <= rem_in;
            root_ff[s+1] <= root_in;
            tag_ff[s+1]  <= tag_ff[s];
         end
      end
   end

   assign root    = root_ff[Steps];
   assign tag_out = tag_ff[Steps];
endmodule

// File: src/sdf_divider.sv
// spring_damper_force direction divider: signed numerator over an
// unsigned 33-bit length, one quotient bit per stage. Depends on sdf_pkg.
module sdf_divider #(
   parameter int unsigned TagW = 8
) (
   input  logic                        clock,
   input  logic                        advance,
   input  logic signed [sdf_pkg::FieldW-1:0] num,
   input  logic [sdf_pkg::RootW-1:0]   den,
   input  logic [TagW-1:0]             tag_in,
   output logic signed [sdf_pkg::DirW-1:0] quo,
   output logic [TagW-1:0]             tag_out
);
   import sdf_pkg::*;

   localparam int unsigned Steps = DivW;
   localparam int unsigned RemW = RootW + 1;

   logic [DivW-1:0]  dvd_ff [Steps+1];
   logic [RemW-1:0]  rem_ff [Steps+1];
   logic [RootW-1:0] den_ff [Steps+1];
   logic             neg_ff [Steps+1];
   logic [TagW-1:0]  tag_ff [Steps+1];

   // magnitude of d * 65536
   always_comb begin
      logic [FieldW:0] mag;
      mag = num[FieldW-1] ? (FieldW+1)'(-$signed({num[FieldW-1], num}))
                          : {1'b0, num};
      dvd_ff[0] = {mag[FieldW-1:0], 16'd0};
      rem_ff[0] = '0;
      den_ff[0] = den;
      neg_ff[0] = num[FieldW-1] && (den != '0);
      tag_ff[0] = tag_in;
   end

   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [RemW-1:0] rem_in;
      logic            qbit;
      always_comb begin
         rem_in = {rem_ff[s][RemW-2:0], dvd_ff[s][DivW-1]};
         qbit = (den_ff[s] != '0) && (rem_in >= {1'b0, den_ff[s]});
         if (qbit) rem_in = rem_in - {1'b0, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            dvd_ff[s+1] <= {dvd_ff[s][DivW-2:0], qbit};
            rem_ff[s+1] <= rem_in;
            den_ff[s+1] <= den_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            tag_ff[s+1] <= tag_ff[s];
         end
      end
   end

   // zero length gives zero quotient since no bit is ever set;
   // the length is never below |d|, so the quotient stays within 2^16
   always_comb begin
      logic signed [DirW-1:0] q;
      q = $signed({1'b0, dvd_ff[Steps][DirW-2:0]});
      quo = neg_ff[Steps] ? -q : q;
   end
   assign tag_out = tag_ff[Steps];
endmodule

// File: src/spring_damper_force.sv
// spring_damper_force top level: Hooke spring with damper, Q16.16.
// Pipeline: input stages a and b, the square roots, the dividers and the tail stages up to the response register.
// Throughput: one transaction per cycle; the pipeline advances whenever
// the output register is free or being taken (shared stall on rsp_tready).
// Reset: synchronous active high, clears valid bits and reloads registers.
module spring_damper_force (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // pos_diff_x/y/z, rest_diff_x/y/z, left_vel_x/y/z, right_vel_x/y/z
   input  logic [sdf_pkg::ReqDataW-1:0]   req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // left_force_x/y/z, right_force_x/y/z, stretch
   output logic [sdf_pkg::RspDataW-1:0]   rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sdf_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [sdf_pkg::FieldW-1:0]     csr_wdata
);
   import sdf_pkg::*;

   localparam int unsigned VelW = 6 * FieldW;
   localparam int unsigned STail = 8;

   // configuration registers
   logic [CoefW-1:0]         k_ff, c_ff;
   logic signed [FieldW-1:0] gx_ff, gy_ff, gz_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= KReset; c_ff <= CReset;
         gx_ff <= GxReset; gy_ff <= GyReset; gz_ff <= GzReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STIFFNESS_K: k_ff <= csr_wdata[CoefW-1:0];
            CSR_DAMPING_C:   c_ff <= csr_wdata[CoefW-1:0];
            CSR_GRAVITY_X:   gx_ff <= csr_wdata;
            CSR_GRAVITY_Y:   gy_ff <= csr_wdata;
            CSR_GRAVITY_Z:   gz_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // global advance: output register empty or being drained
   logic advance;
   assign advance = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // valid bits of the whole pipe
   localparam int unsigned Depth = 2 + RootW + DivW + STail;
   logic [Depth-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[Depth-2:0], req_tvalid};
   end

   // stage a: absolute values
   logic signed [FieldW-1:0] d_a_ff [3];
   logic [FieldW-1:0]        ad_a_ff [3], ar_a_ff [3];
   logic [VelW-1:0]          v_a_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            logic signed [FieldW-1:0] dd, rr;
            dd = req_tdata[i*FieldW +: FieldW];
            rr = req_tdata[(3+i)*FieldW +: FieldW];
            d_a_ff[i]  <= dd;
            ad_a_ff[i] <= dd[FieldW-1] ? FieldW'(-dd) : dd;
            ar_a_ff[i] <= rr[FieldW-1] ? FieldW'(-rr) : rr;
         end
         v_a_ff <= req_tdata[6*FieldW +: VelW];
      end
   end

   // stage b: squares, registered before the sum
   logic [2*FieldW-1:0] sd_b_ff [3], sr_b_ff [3];
   logic signed [FieldW-1:0] d_b_ff [3];
   logic [VelW-1:0] v_b_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            sd_b_ff[i] <= ad_a_ff[i] * ad_a_ff[i];
            sr_b_ff[i] <= ar_a_ff[i] * ar_a_ff[i];
         end
         d_b_ff <= d_a_ff;
         v_b_ff <= v_a_ff;
      end
   end

   logic [SumW-1:0] sum_d, sum_r;
   assign sum_d = SumW'(sd_b_ff[0]) + SumW'(sd_b_ff[1]) + SumW'(sd_b_ff[2]);
   assign sum_r = SumW'(sr_b_ff[0]) + SumW'(sr_b_ff[1]) + SumW'(sr_b_ff[2]);

   // two square roots side by side; the direction and velocities ride as tag
   localparam int unsigned T1W = 3 * FieldW + VelW;
   logic [RootW-1:0] len_q, rest_q;
   logic [T1W-1:0]   t1_out;
   logic [0:0]       t1_dummy;

   sdf_isqrt #(.TagW(T1W)) u_sqrt_len (
      .clock, .advance, .rad(sum_d),
      .tag_in({v_b_ff, d_b_ff[2], d_b_ff[1], d_b_ff[0]}),
      .root(len_q), .tag_out(t1_out));
   sdf_isqrt #(.TagW(1)) u_sqrt_rest (
      .clock, .advance, .rad(sum_r), .tag_in(1'b0),
      .root(rest_q), .tag_out(t1_dummy));

   // stretch and the rest of the payload travel through the divider tags
   localparam int unsigned XW = RootW + 1;
   logic signed [XW-1:0] x_c;
   assign x_c = $signed({1'b0, len_q}) - $signed({1'b0, rest_q});

   localparam int unsigned T2W = VelW + XW + 1;
   logic signed [DirW-1:0] u_q [3];
   logic [T2W-1:0] t2 [3];
   for (genvar i = 0; i < 3; i++) begin : g_div
      sdf_divider #(.TagW(T2W)) u_div (
         .clock, .advance,
         .num(t1_out[i*FieldW +: FieldW]), .den(len_q),
         .tag_in({t1_dummy, x_c, t1_out[3*FieldW +: VelW]}),
         .quo(u_q[i]), .tag_out(t2[i]));
   end

   logic [VelW-1:0] v_d;
   logic signed [XW-1:0] x_d;
   assign v_d = t2[0][VelW-1:0];
   assign x_d = $signed(t2[0][VelW +: XW]);

   // tail stage 1: k*x and the dot-product products
   localparam int unsigned PW = 2 * FieldW + 20;
   logic signed [XW+CoefW:0] kx_1_ff;
   logic signed [PW-1:0] pl_1_ff [3], pr_1_ff [3];
   logic signed [DirW-1:0] u_1_ff [3];
   logic signed [XW-1:0] x_1_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         kx_1_ff <= x_d * $signed({1'b0, k_ff});
         for (int i = 0; i < 3; i++) begin
            pl_1_ff[i] <= $signed(v_d[i*FieldW +: FieldW]) * u_q[i];
            pr_1_ff[i] <= $signed(v_d[(3+i)*FieldW +: FieldW]) * u_q[i];
         end
         u_1_ff <= u_q;
         x_1_ff <= x_d;
      end
   end

   // tail stage 2: spring scalar and dot sums, right end uses -u
   logic signed [XW+CoefW-15:0] s_2_ff;
   logic signed [PW+1:0] dl_2_ff, dr_2_ff;
   logic signed [DirW-1:0] u_2_ff [3];
   logic signed [XW-1:0] x_2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s_2_ff  <= (XW+CoefW-14)'(-(kx_1_ff >>> 16));
         dl_2_ff <= pl_1_ff[0] + pl_1_ff[1] + pl_1_ff[2];
         dr_2_ff <= -(pr_1_ff[0] + pr_1_ff[1] + pr_1_ff[2]);
         u_2_ff <= u_1_ff; x_2_ff <= x_1_ff;
      end
   end

   // tail stage 3: shift and clamp the dot products
   localparam int unsigned QW = 34;
   localparam logic signed [PW+1:0] DotLim = (PW+2)'(64'sd4294967295);
   logic signed [QW-1:0] p_l_3_ff, p_r_3_ff;
   logic signed [XW+CoefW-15:0] s_3_ff;
   logic signed [DirW-1:0] u_3_ff [3];
   logic signed [XW-1:0] x_3_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         logic signed [PW+1:0] a, b;
         a = dl_2_ff >>> 16;
         b = dr_2_ff >>> 16;
         p_l_3_ff <= (a > DotLim) ? QW'(DotLim) : (a < -DotLim) ? QW'(-DotLim) : QW'(a);
         p_r_3_ff <= (b > DotLim) ? QW'(DotLim) : (b < -DotLim) ? QW'(-DotLim) : QW'(b);
         s_3_ff <= s_2_ff; u_3_ff <= u_2_ff; x_3_ff <= x_2_ff;
      end
   end

   // tail stage 4: c*p and s*u products
   localparam int unsigned CPW = QW + CoefW + 1;
   localparam int unsigned SUW = XW + CoefW - 14 + DirW;
   logic signed [CPW-1:0] cl_4_ff, cr_4_ff;
   logic signed [SUW-1:0] su_4_ff [3];
   logic signed [DirW-1:0] u_4_ff [3];
   logic signed [XW-1:0] x_4_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         cl_4_ff <= p_l_3_ff * $signed({1'b0, c_ff});
         cr_4_ff <= p_r_3_ff * $signed({1'b0, c_ff});
         for (int i = 0; i < 3; i++) su_4_ff[i] <= s_3_ff * u_3_ff[i];
         u_4_ff <= u_3_ff; x_4_ff <= x_3_ff;
      end
   end

   // tail stage 5: q terms and spring terms
   logic signed [CPW-17:0] ql_5_ff, qr_5_ff;
   logic signed [SUW-17:0] t_5_ff [3];
   logic signed [DirW-1:0] u_5_ff [3];
   logic signed [XW-1:0] x_5_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         ql_5_ff <= (CPW-16)'(cl_4_ff >>> 16);
         qr_5_ff <= (CPW-16)'(cr_4_ff >>> 16);
         for (int i = 0; i < 3; i++) t_5_ff[i] <= (SUW-16)'(su_4_ff[i] >>> 16);
         u_5_ff <= u_4_ff; x_5_ff <= x_4_ff;
      end
   end

   // tail stage 6: q * w products
   localparam int unsigned QWW = CPW - 16 + DirW;
   logic signed [QWW-1:0] el_6_ff [3], er_6_ff [3];
   logic signed [SUW-17:0] t_6_ff [3];
   logic signed [XW-1:0] x_6_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            el_6_ff[i] <= ql_5_ff * u_5_ff[i];
            er_6_ff[i] <= qr_5_ff * (-u_5_ff[i]);
         end
         t_6_ff <= t_5_ff; x_6_ff <= x_5_ff;
      end
   end

   // tail stage 7: damping terms
   logic signed [QWW-16:0] el_7_ff [3], er_7_ff [3];
   logic signed [SUW-17:0] t_7_ff [3];
   logic signed [XW-1:0] x_7_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            el_7_ff[i] <= -(QWW-15)'(el_6_ff[i] >>> 16);
            er_7_ff[i] <= -(QWW-15)'(er_6_ff[i] >>> 16);
         end
         t_7_ff <= t_6_ff; x_7_ff <= x_6_ff;
      end
   end

   // tail stage 8: sums, saturation and the response register
   logic signed [FieldW-1:0] g [3];
   assign g[0] = gx_ff; assign g[1] = gy_ff; assign g[2] = gz_ff;
   logic [RspDataW-1:0] rsp_in;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rsp_in[i*FieldW +: FieldW] = sat32(128'(g[i]) + 128'(t_7_ff[i]) + 128'(el_7_ff[i]));
         rsp_in[(3+i)*FieldW +: FieldW] =
            sat32(128'(g[i]) - 128'(t_7_ff[i]) + 128'(er_7_ff[i]));
      end
      rsp_in[6*FieldW +: FieldW] = sat32(128'(x_7_ff));
   end

   logic [RspDataW-1:0] rsp_data_ff;
   always_ff @(posedge clock) begin
      if (advance) rsp_data_ff <= rsp_in;
   end
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = vld_ff[Depth-1];
endmodule

// File: src/sdf_checker.sv
// spring_damper_force port checker and its bind statement.
// Depends on sdf_pkg and the top level's ports.
module sdf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [sdf_pkg::RspDataW-1:0] rsp_tdata,
   input logic                         csr_ready
);
   import sdf_pkg::*;

   // no response right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid) else $error("response valid after reset");

   // a stalled response keeps its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // input side stalls whenever the output does
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready) else $error("ready while stalled");

   // configuration always taken
   a_csr: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr not ready");
endmodule

bind spring_damper_force sdf_checker u_sdf_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .csr_ready);

// File: tb/spring_damper_force_tb.sv
// spring_damper_force testbench: random and directed spring transactions
// checked against an in-bench fixed-point force predictor.
// Depends on sdf_pkg and spring_damper_force from src.
module spring_damper_force_tb;
   import sdf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [127:0] wide_type;
   localparam int unsigned LatencyWait = 120;
   localparam int unsigned CycleLimit = 400000;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_valid;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index;
   logic [FieldW-1:0]   csr_wdata;

   spring_damper_force i_dut (.*);

   // register copies used by the predictor
   wide_type k_coef, c_coef, grav [3];

   logic [ReqDataW-1:0] pending_springs [$];
   logic [RspDataW-1:0] expected_forces [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_gap = 0, recv_gap = 0, recv_block = 0;
   bit          send_idle_on = 1, recv_idle_on = 1;

   string out_names [OutFields] = '{"left_force_x", "left_force_y", "left_force_z",
      "right_force_x", "right_force_y", "right_force_z", "stretch"};

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // floor square root of a non-negative sum
   function automatic wide_type root_floor(input logic [127:0] n);
      logic [127:0] r, b;
      r = 0;
      b = 128'd1 << 64;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return wide_type'(r);
   endfunction

   function automatic logic [FieldW-1:0] clip_q16(input wide_type v);
      if (v > 2147483647) return 32'h7fffffff;
      if (v < -wide_type'(64'sd2147483648)) return 32'h80000000;
      return v[FieldW-1:0];
   endfunction

   // spring plus damper forces for one spring
   function automatic logic [RspDataW-1:0] spring_forces(input logic [ReqDataW-1:0] req);
      wide_type f [InFields];
      wide_type u [3];
      wide_type e [2][3];
      wide_type t [3];
      wide_type len, rest, x, s, dot, p, q, w, sq_d, sq_r;
      logic [RspDataW-1:0] res;
      for (int i = 0; i < InFields; i++) f[i] = $signed(req[i*FieldW +: FieldW]);
      sq_d = 0;
      sq_r = 0;
      for (int i = 0; i < 3; i++) begin
         sq_d = sq_d + f[i] * f[i];
         sq_r = sq_r + f[3+i] * f[3+i];
      end
      len = root_floor(sq_d);
      rest = root_floor(sq_r);
      x = len - rest;
      for (int i = 0; i < 3; i++) u[i] = (len != 0) ? (f[i] * 65536) / len : 0;
      s = -((k_coef * x) >>> 16);
      for (int i = 0; i < 3; i++) t[i] = (s * u[i]) >>> 16;
      // damping along each end's own direction
      for (int side = 0; side < 2; side++) begin
         dot = 0;
         for (int i = 0; i < 3; i++) begin
            w = side ? -u[i] : u[i];
            dot = dot + f[6+side*3+i] * w;
         end
         p = dot >>> 16;
         if (p > 64'sd4294967295) p = 64'sd4294967295;
         if (p < -64'sd4294967295) p = -64'sd4294967295;
         q = (c_coef * p) >>> 16;
         for (int i = 0; i < 3; i++) begin
            w = side ? -u[i] : u[i];
            e[side][i] = -((q * w) >>> 16);
         end
      end
      for (int i = 0; i < 3; i++) begin
         res[i*FieldW +: FieldW] = clip_q16(grav[i] + t[i] + e[0][i]);
         res[(3+i)*FieldW +: FieldW] = clip_q16(grav[i] - t[i] + e[1][i]);
      end
      res[6*FieldW +: FieldW] = clip_q16(x);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("mismatch %s: expected %h got %h at cycle %0d", what, want, got, cycle_count);
      error_count++;
   endtask

   // append one spring to the driver queue
   task automatic queue_spring(input logic [ReqDataW-1:0] spring);
      pending_springs = {pending_springs, spring};
   endtask

   function automatic int unsigned idle_draw(input bit on);
      if (!on) return 0;
      return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
   endfunction

   // request driver: one transaction per slot, gaps drawn per item
   always @(posedge clock) begin
      logic nv;
      logic [ReqDataW-1:0] nd;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) expected_forces = {expected_forces, spring_forces(req_tdata)};
         nv = 1'b0;
         nd = req_tdata;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_springs.size() > 0) begin
            nd = pending_springs.pop_front();
            nv = 1'b1;
            send_gap = idle_draw(send_idle_on);
         end
         req_tvalid <= nv;
         req_tdata <= nd;
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      logic [RspDataW-1:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_forces.size() == 0) begin
               $display("unexpected response transaction at cycle %0d", cycle_count);
               error_count++;
            end else begin
               want = expected_forces.pop_front();
               for (int i = 0; i < OutFields; i++)
                  if (want[i*FieldW +: FieldW] !== rsp_tdata[i*FieldW +: FieldW])
                     report_mismatch(out_names[i], want[i*FieldW +: FieldW],
                                     rsp_tdata[i*FieldW +: FieldW]);
            end
            recv_gap = idle_draw(recv_idle_on);
         end
         if (recv_block > 0) begin
            recv_block--;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("spring_damper_force regression: fail");
         $finish;
      end
   end

   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [FieldW-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_STIFFNESS_K: k_coef = wide_type'({1'b0, data[CoefW-1:0]});
         CSR_DAMPING_C:   c_coef = wide_type'({1'b0, data[CoefW-1:0]});
         CSR_GRAVITY_X:   grav[0] = $signed(data);
         CSR_GRAVITY_Y:   grav[1] = $signed(data);
         CSR_GRAVITY_Z:   grav[2] = $signed(data);
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20) : -$urandom_range(0, 1 << 20);
         2: return $urandom_range(0, 8) - 4;
         3: case ($urandom_range(0, 3))
               0: return 32'h7fffffff;
               1: return 32'h80000000;
               2: return 32'h0;
               default: return 32'hffffffff;
            endcase
         default: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 24) : -$urandom_range(0, 1 << 24);
      endcase
   endfunction

   function automatic logic [ReqDataW-1:0] make_spring(input logic [31:0] px, py, pz,
      rx, ry, rz, lvx, lvy, lvz, rvx, rvy, rvz);
      return {rvz, rvy, rvx, lvz, lvy, lvx, rz, ry, rx, pz, py, px};
   endfunction

   function automatic logic [ReqDataW-1:0] rand_spring();
      logic [ReqDataW-1:0] r;
      for (int i = 0; i < InFields; i++) r[i*FieldW +: FieldW] = rand_field();
      // often a rest vector close to the current one
      if ($urandom_range(0, 2) == 0)
         for (int i = 0; i < 3; i++)
            r[(3+i)*FieldW +: FieldW] = r[i*FieldW +: FieldW] + ($urandom_range(0, 2048) - 1024);
      return r;
   endfunction

   task automatic drain();
      while (pending_springs.size() > 0 || req_tvalid || expected_forces.size() > 0)
         @(posedge clock);
      repeat (LatencyWait) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      k_coef = 65536;
      c_coef = 0;
      grav[0] = 0;
      grav[1] = -642908;
      grav[2] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero length, extremes, tiny vectors, saturating stretch
      queue_spring(make_spring(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_spring(make_spring(0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
         5, 6, 7, 8, 9, 10));
      queue_spring(make_spring(1, 1, 1, 0, 0, 0, 32'h7fffffff, 32'h7fffffff,
         32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000));
      queue_spring(make_spring(-1, 0, 0, 1, 0, 0, 100, 0, 0, -100, 0, 0));
      queue_spring(make_spring(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0,
         32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 0));
      queue_spring(make_spring(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
         1, 1, 1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 1, 1));
      queue_spring(make_spring(32'h00020000, 0, 0, 32'h00010000, 0, 0,
         32'h00010000, 0, 0, 0, 32'h00010000, 0));
      queue_spring(make_spring(0, -3, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      drain();
      csr_write(CSR_DAMPING_C, 32'h7fffffff);
      csr_write(CSR_STIFFNESS_K, 32'hffffffff);
      for (int i = 0; i < 8; i++) queue_spring(rand_spring());
      queue_spring(make_spring(1, 1, 1, 0, 0, 0, 32'h7fffffff, 32'h7fffffff,
         32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000));
      queue_spring(make_spring(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
         0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0));
      drain();

      // random phases under several register settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               csr_write(CSR_STIFFNESS_K, 32'h0000_0000);
               csr_write(CSR_DAMPING_C, 32'h0000_0000);
               csr_write(CSR_GRAVITY_X, 32'h7fffffff);
               csr_write(CSR_GRAVITY_Y, 32'h80000000);
               csr_write(CSR_GRAVITY_Z, 32'h7fffffff);
            end
            1: begin
               csr_write(CSR_STIFFNESS_K, 32'h000a0000);
               csr_write(CSR_DAMPING_C, 32'h00008000);
               csr_write(CSR_GRAVITY_X, 0);
               csr_write(CSR_GRAVITY_Y, -642908);
               csr_write(CSR_GRAVITY_Z, 0);
            end
            2: begin
               csr_write(CSR_STIFFNESS_K, 32'h7fffffff);
               csr_write(CSR_DAMPING_C, 32'hffffffff);
               csr_write(CSR_GRAVITY_Z, 32'h80000000);
            end
            default: begin
               csr_write(CSR_STIFFNESS_K, $urandom);
               csr_write(CSR_DAMPING_C, $urandom);
               csr_write(CSR_GRAVITY_X, $urandom);
               csr_write(CSR_GRAVITY_Y, $urandom);
               csr_write(CSR_GRAVITY_Z, $urandom);
            end
         endcase
         // writes to unused indexes must change nothing
         csr_write(CSR_GRAVITY_Z + 3'd1 + 3'($urandom_range(0, 2)), $urandom);
         send_idle_on = (ph != 3);
         recv_idle_on = (ph != 3) && (ph != 4);
         // long receiver hold-off while the sender keeps offering
         if (ph == 2) begin
            @(negedge clock);
            recv_block = 400;
         end
         for (int i = 0; i < 225; i++) queue_spring(rand_spring());
         drain();
      end

      if (error_count == 0 && expected_forces.size() == 0) begin
         $display("spring_damper_force regression: pass");
      end else begin
         $display("spring_damper_force regression: fail");
      end
      $finish;
   end

endmodule

// File: files.f
src/sdf_pkg.sv
src/sdf_isqrt.sv
src/sdf_divider.sv
src/spring_damper_force.sv
src/sdf_checker.sv
tb/spring_damper_force_tb.sv
